@@ src/ter_pkg.sv @@
// ----------------------------------------------------------------------------
// ter_pkg: shared types and constants of the triangle edge rasterizer
// Field widths, register indexes, request codes and the record that the
// front part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package ter_pkg;

    localparam int VERT_W      = 16;
    localparam int COLOR_W     = 32;
    localparam int OUT_COORD_W = 12;
    localparam int INDEX_W     = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam int FRAME_W_RESET = 640;
    localparam int FRAME_H_RESET = 480;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic signed [VERT_W-1:0] vert_t;

    typedef struct packed {
        vert_t v0x;
        vert_t v0y;
        vert_t v1x;
        vert_t v1y;
        vert_t v2x;
        vert_t v2y;
    } tri_t;

    // What a queued record asks of the back part
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_IDLE,
        KIND_WALK
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t kind;
        logic      done;
    } rec_ctl_t;

endpackage

@@ src/ter_queue.sv @@
// ----------------------------------------------------------------------------
// ter_queue: short record queue between front and back
// Register array with read and write pointers; push only when not full.
// ----------------------------------------------------------------------------
module ter_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ src/ter_front.sv @@
// ----------------------------------------------------------------------------
// ter_front: request classifier and box walker
// Forms the pixel bounding box on a load beat and steps through it one
// pixel per tick beat, emitting one record per beat for the back part.
// ----------------------------------------------------------------------------
module ter_front #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4,
    localparam int CW = $clog2(MAX_DIM),
    localparam int FW = $clog2(MAX_DIM + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              req_type,
    input  ter_pkg::tri_t     tri_in,
    input  logic [FW-1:0]     width_clamped,
    input  logic [FW-1:0]     height_clamped,
    output ter_pkg::rec_ctl_t rec_ctl,
    output logic [CW-1:0]     rec_x,
    output logic [CW-1:0]     rec_y
);

    localparam int BW = ((FW > ter_pkg::VERT_W) ? FW : ter_pkg::VERT_W) + 2;

    logic          walking_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] lo_x_reg;
    logic [CW-1:0] lo_y_reg;
    logic [CW-1:0] hi_x_reg;
    logic [CW-1:0] hi_y_reg;

    ter_pkg::vert_t    mn_x, mx_x, mn_y, mx_y;
    logic signed [BW-1:0] fl_mn_x, fl_mx_x, fl_mn_y, fl_mx_y;
    logic signed [BW-1:0] lim_x, lim_y;
    logic signed [BW-1:0] lo_x, lo_y, hi_x, hi_y;
    logic                 box_empty;
    logic                 col_end;
    logic                 row_end;

    function automatic ter_pkg::vert_t min3(ter_pkg::vert_t a, ter_pkg::vert_t b,
                                            ter_pkg::vert_t c);
        ter_pkg::vert_t m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic ter_pkg::vert_t max3(ter_pkg::vert_t a, ter_pkg::vert_t b,
                                            ter_pkg::vert_t c);
        ter_pkg::vert_t m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    // Bounding box: arithmetic shift floors to whole pixels
    always_comb
    begin
        mn_x    = min3(tri_in.v0x, tri_in.v1x, tri_in.v2x);
        mx_x    = max3(tri_in.v0x, tri_in.v1x, tri_in.v2x);
        mn_y    = min3(tri_in.v0y, tri_in.v1y, tri_in.v2y);
        mx_y    = max3(tri_in.v0y, tri_in.v1y, tri_in.v2y);
        fl_mn_x = BW'(mn_x >>> FRAC_BITS);
        fl_mx_x = BW'(mx_x >>> FRAC_BITS);
        fl_mn_y = BW'(mn_y >>> FRAC_BITS);
        fl_mx_y = BW'(mx_y >>> FRAC_BITS);
        lim_x   = $signed(BW'(width_clamped) - BW'(1));
        lim_y   = $signed(BW'(height_clamped) - BW'(1));
        lo_x    = fl_mn_x[BW-1] ? '0 : fl_mn_x;
        lo_y    = fl_mn_y[BW-1] ? '0 : fl_mn_y;
        hi_x    = (fl_mx_x > lim_x) ? lim_x : fl_mx_x;
        hi_y    = (fl_mx_y > lim_y) ? lim_y : fl_mx_y;
        box_empty = (hi_x < lo_x) || (hi_y < lo_y);
    end

    assign col_end = (col_reg >= hi_x_reg);
    assign row_end = (row_reg >= hi_y_reg);

    always_comb
    begin
        rec_ctl.kind = ter_pkg::KIND_IDLE;
        rec_ctl.done = 1'b1;
        rec_x        = '0;
        rec_y        = '0;
        if (req_type == ter_pkg::REQ_LOAD)
        begin
            rec_ctl.kind = ter_pkg::KIND_LOAD;
            rec_ctl.done = box_empty;
        end
        else if (walking_reg)
        begin
            rec_ctl.kind = ter_pkg::KIND_WALK;
            rec_ctl.done = col_end && row_end;
            rec_x        = col_reg;
            rec_y        = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            lo_x_reg    <= '0;
            lo_y_reg    <= '0;
            hi_x_reg    <= '0;
            hi_y_reg    <= '0;
        end
        else if (accept)
        begin
            if (req_type == ter_pkg::REQ_LOAD)
            begin
                if (box_empty)
                begin
                    walking_reg <= 1'b0;
                    col_reg     <= '0;
                    row_reg     <= '0;
                    lo_x_reg    <= '0;
                    lo_y_reg    <= '0;
                    hi_x_reg    <= '0;
                    hi_y_reg    <= '0;
                end
                else
                begin
                    walking_reg <= 1'b1;
                    col_reg     <= CW'(lo_x);
                    row_reg     <= CW'(lo_y);
                    lo_x_reg    <= CW'(lo_x);
                    lo_y_reg    <= CW'(lo_y);
                    hi_x_reg    <= CW'(hi_x);
                    hi_y_reg    <= CW'(hi_y);
                end
            end
            else if (walking_reg)
            begin
                // advance column first, wrap to next row at the right edge
                if (col_end)
                begin
                    col_reg <= lo_x_reg;
                    if (row_end)
                    begin
                        walking_reg <= 1'b0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

endmodule

@@ src/ter_back.sv @@
// ----------------------------------------------------------------------------
// ter_back: edge test and index pipeline
// Stage 1 offsets the pixel centre from each edge start, stage 2 forms the
// edge products and the row offset, stage 3 signs the edge functions and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module ter_back #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4,
    localparam int CW = $clog2(MAX_DIM),
    localparam int FW = $clog2(MAX_DIM + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rec_valid,
    output logic                            rec_ready,
    input  ter_pkg::rec_ctl_t               rec_ctl,
    input  logic [CW-1:0]                   rec_x,
    input  logic [CW-1:0]                   rec_y,
    input  ter_pkg::tri_t                   rec_tri,
    input  logic [ter_pkg::COLOR_W-1:0]     rec_color,
    input  logic [FW-1:0]                   width_clamped,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_covered,
    output logic                            out_done,
    output logic [ter_pkg::OUT_COORD_W-1:0] out_x,
    output logic [ter_pkg::OUT_COORD_W-1:0] out_y,
    output logic [ter_pkg::INDEX_W-1:0]     out_index,
    output logic [ter_pkg::COLOR_W-1:0]     out_color
);

    localparam int DBL_W = ter_pkg::VERT_W + 1;
    localparam int ED_W  = DBL_W + 1;
    localparam int PW    = CW + 1 + FRAC_BITS;
    localparam int SW    = ((PW > DBL_W) ? PW : DBL_W) + 2;
    localparam int PRW   = SW + ED_W;
    localparam int EW    = PRW + 1;
    localparam int IW    = CW + FW;

    // edge i runs from vertex EDGE_A[i] to vertex EDGE_B[i]
    localparam int EDGE_A [3] = '{1, 2, 0};
    localparam int EDGE_B [3] = '{2, 0, 1};

    logic advance;

    // triangle state, updated as a load record passes stage 1
    logic signed [DBL_W-1:0]       ax_reg [3];
    logic signed [DBL_W-1:0]       ay_reg [3];
    logic signed [ED_W-1:0]        ex_reg [3];
    logic signed [ED_W-1:0]        ey_reg [3];
    logic [ter_pkg::COLOR_W-1:0]   color_reg;

    logic signed [DBL_W-1:0] vx [3];
    logic signed [DBL_W-1:0] vy [3];
    logic [PW-1:0]           px;
    logic [PW-1:0]           py;
    logic signed [SW-1:0]    dx [3];
    logic signed [SW-1:0]    dy [3];
    logic                    is_load;

    logic                        s1_valid_reg;
    ter_pkg::rec_kind_t          s1_kind_reg;
    logic                        s1_done_reg;
    logic [CW-1:0]               s1_x_reg;
    logic [CW-1:0]               s1_y_reg;
    logic [ter_pkg::COLOR_W-1:0] s1_color_reg;
    logic signed [SW-1:0]        s1_dx_reg [3];
    logic signed [SW-1:0]        s1_dy_reg [3];
    logic signed [ED_W-1:0]      s1_ex_reg [3];
    logic signed [ED_W-1:0]      s1_ey_reg [3];

    logic                        s2_valid_reg;
    ter_pkg::rec_kind_t          s2_kind_reg;
    logic                        s2_done_reg;
    logic [CW-1:0]               s2_x_reg;
    logic [CW-1:0]               s2_y_reg;
    logic [ter_pkg::COLOR_W-1:0] s2_color_reg;
    logic signed [PRW-1:0]       s2_pa_reg [3];
    logic signed [PRW-1:0]       s2_pb_reg [3];
    logic [IW-1:0]               s2_row_reg;

    logic signed [EW-1:0] ef [3];
    logic                 all_ge;
    logic                 all_le;

    logic                                out_valid_reg;
    logic                                covered_reg;
    logic                                done_reg;
    logic [ter_pkg::OUT_COORD_W-1:0]     x_reg;
    logic [ter_pkg::OUT_COORD_W-1:0]     y_reg;
    logic [ter_pkg::INDEX_W-1:0]         index_reg;
    logic [ter_pkg::COLOR_W-1:0]         ocolor_reg;

    // the whole pipe moves together; the output register holds on stall
    assign advance   = !out_valid_reg || out_ready;
    assign rec_ready = advance;
    assign is_load   = rec_valid && (rec_ctl.kind == ter_pkg::KIND_LOAD);

    always_comb
    begin
        vx[0] = {rec_tri.v0x, 1'b0};
        vy[0] = {rec_tri.v0y, 1'b0};
        vx[1] = {rec_tri.v1x, 1'b0};
        vy[1] = {rec_tri.v1y, 1'b0};
        vx[2] = {rec_tri.v2x, 1'b0};
        vy[2] = {rec_tri.v2y, 1'b0};
        // pixel centre, doubled so it stays integral
        px = PW'({rec_x, 1'b1}) << FRAC_BITS;
        py = PW'({rec_y, 1'b1}) << FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            dx[i] = $signed(SW'(px)) - SW'(ax_reg[i]);
            dy[i] = $signed(SW'(py)) - SW'(ay_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ef[i] = EW'(s2_pa_reg[i]) - EW'(s2_pb_reg[i]);
        end
        all_ge = !ef[0][EW-1] && !ef[1][EW-1] && !ef[2][EW-1];
        all_le = (ef[0][EW-1] || ef[0] == '0) && (ef[1][EW-1] || ef[1] == '0)
              && (ef[2][EW-1] || ef[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= rec_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (is_load)
            begin
                color_reg <= rec_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (is_load)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ax_reg[i] <= vx[EDGE_A[i]];
                    ay_reg[i] <= vy[EDGE_A[i]];
                    ex_reg[i] <= ED_W'(vx[EDGE_B[i]]) - ED_W'(vx[EDGE_A[i]]);
                    ey_reg[i] <= ED_W'(vy[EDGE_B[i]]) - ED_W'(vy[EDGE_A[i]]);
                end
            end

            s1_kind_reg  <= rec_ctl.kind;
            s1_done_reg  <= rec_ctl.done;
            s1_x_reg     <= rec_x;
            s1_y_reg     <= rec_y;
            s1_color_reg <= is_load ? rec_color : color_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_dx_reg[i] <= dx[i];
                s1_dy_reg[i] <= dy[i];
                s1_ex_reg[i] <= ex_reg[i];
                s1_ey_reg[i] <= ey_reg[i];
            end

            s2_kind_reg  <= s1_kind_reg;
            s2_done_reg  <= s1_done_reg;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_color_reg <= s1_color_reg;
            s2_row_reg   <= IW'(s1_y_reg) * IW'(width_clamped);
            for (int i = 0; i < 3; i++)
            begin
                s2_pa_reg[i] <= PRW'(s1_dx_reg[i]) * PRW'(s1_ey_reg[i]);
                s2_pb_reg[i] <= PRW'(s1_dy_reg[i]) * PRW'(s1_ex_reg[i]);
            end

            covered_reg <= (s2_kind_reg == ter_pkg::KIND_WALK) && (all_ge || all_le);
            done_reg    <= s2_done_reg;
            x_reg       <= ter_pkg::OUT_COORD_W'(s2_x_reg);
            y_reg       <= ter_pkg::OUT_COORD_W'(s2_y_reg);
            index_reg   <= ter_pkg::INDEX_W'((IW + 1)'(s2_row_reg) + (IW + 1)'(s2_x_reg));
            ocolor_reg  <= s2_color_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_covered = covered_reg;
    assign out_done    = done_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_index   = index_reg;
    assign out_color   = ocolor_reg;

endmodule

@@ src/triangle_edge_rasterizer.sv @@
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer: edge-function triangle rasterizer, top level
// Load beats latch a triangle and colour; tick beats test one box pixel.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries request beats. tuser 0 loads a triangle (three signed
//   fixed-point vertices and a colour), tuser 1 is a tick that tests the
//   next pixel of the bounding box in row order. Every request beat gives
//   exactly one result beat on m_*: tuser is the coverage flag, tlast marks
//   the last pixel of the walk (or an empty box, or a tick while idle).
//   cfg_* writes frame_width (index 0) and frame_height (index 1); write
//   only while no beat is in flight.
// Timing:
//   One beat per cycle in and out while m_tready stays high. Each request
//   beat passes the queue, then one stage for the edge offsets, one
//   for the edge multipliers and row offset, one for the sign test and
//   output register. A 4-entry queue sits between the box walker and the
//   edge pipeline, so s_tready drops only once that queue is full while
//   m_tready is low. Reset leaves the block idle with a 640x480 frame and
//   a zero colour.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
    // fill_blue, fill_green, fill_red, fill_alpha
    input  logic [127:0]                       s_tdata,
    // req_type
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_x, pixel_y, pixel_index, out_blue, out_green, out_red, out_alpha
    output logic [79:0]                        m_tdata,
    // covered
    output logic                               m_tuser,
    // walk_done
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ter_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ter_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW      = $clog2(MAX_DIM);
    localparam int FW      = $clog2(MAX_DIM + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_WIDTH = $bits(ter_pkg::rec_ctl_t) + 2 * CW + $bits(ter_pkg::tri_t)
                           + ter_pkg::COLOR_W;

    logic [ter_pkg::CFG_DATA_W-1:0] frame_width_reg;
    logic [ter_pkg::CFG_DATA_W-1:0] frame_height_reg;
    logic [FW-1:0]                  width_clamped;
    logic [FW-1:0]                  height_clamped;

    ter_pkg::tri_t               tri_in;
    logic [ter_pkg::COLOR_W-1:0] fill_color;
    logic                        q_push;
    logic                        q_full;
    logic                        q_pop_valid;
    logic                        q_pop_ready;
    logic [Q_WIDTH-1:0]          q_push_data;
    logic [Q_WIDTH-1:0]          q_pop_data;

    ter_pkg::rec_ctl_t           push_ctl;
    logic [CW-1:0]               push_x;
    logic [CW-1:0]               push_y;
    ter_pkg::rec_ctl_t           pop_ctl;
    logic [CW-1:0]               pop_x;
    logic [CW-1:0]               pop_y;
    ter_pkg::tri_t               pop_tri;
    logic [ter_pkg::COLOR_W-1:0] pop_color;

    logic [ter_pkg::OUT_COORD_W-1:0] res_x;
    logic [ter_pkg::OUT_COORD_W-1:0] res_y;
    logic [ter_pkg::INDEX_W-1:0]     res_index;
    logic [ter_pkg::COLOR_W-1:0]     res_color;

    // zero reads as one, oversize as the largest frame
    function automatic logic [FW-1:0] clamp_dim(logic [ter_pkg::CFG_DATA_W-1:0] v);
        if (v == '0)
        begin
            return FW'(1);
        end
        if (32'(v) > MAX_DIM)
        begin
            return FW'(MAX_DIM);
        end
        return FW'(v);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ter_pkg::CFG_DATA_W'(ter_pkg::FRAME_W_RESET);
            frame_height_reg <= ter_pkg::CFG_DATA_W'(ter_pkg::FRAME_H_RESET);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ter_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                ter_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign width_clamped  = clamp_dim(frame_width_reg);
    assign height_clamped = clamp_dim(frame_height_reg);

    assign tri_in.v0x = s_tdata[15:0];
    assign tri_in.v0y = s_tdata[31:16];
    assign tri_in.v1x = s_tdata[47:32];
    assign tri_in.v1y = s_tdata[63:48];
    assign tri_in.v2x = s_tdata[79:64];
    assign tri_in.v2y = s_tdata[95:80];
    assign fill_color = s_tdata[127:96];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    ter_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (q_push),
        .req_type       (s_tuser),
        .tri_in         (tri_in),
        .width_clamped  (width_clamped),
        .height_clamped (height_clamped),
        .rec_ctl        (push_ctl),
        .rec_x          (push_x),
        .rec_y          (push_y)
    );

    assign q_push_data = {push_ctl, push_x, push_y, tri_in, fill_color};

    ter_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data)
    );

    assign {pop_ctl, pop_x, pop_y, pop_tri, pop_color} = q_pop_data;

    ter_back #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (q_pop_valid),
        .rec_ready     (q_pop_ready),
        .rec_ctl       (pop_ctl),
        .rec_x         (pop_x),
        .rec_y         (pop_y),
        .rec_tri       (pop_tri),
        .rec_color     (pop_color),
        .width_clamped (width_clamped),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_covered   (m_tuser),
        .out_done      (m_tlast),
        .out_x         (res_x),
        .out_y         (res_y),
        .out_index     (res_index),
        .out_color     (res_color)
    );

    assign m_tdata = {res_color, res_index, res_y, res_x};

`ifndef SYNTH
    // a finished walk is never followed by another walk pixel without a load
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && push_ctl.kind == ter_pkg::KIND_WALK && push_ctl.done)
        |=> !(q_push && push_ctl.kind == ter_pkg::KIND_WALK))
        else $error("walk pixel issued after the last pixel of the box");

    // consecutive walk pixels step one column right or move to the next row
    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && push_ctl.kind == ter_pkg::KIND_WALK && !push_ctl.done)
        ##1 (q_push && push_ctl.kind == ter_pkg::KIND_WALK)
        |-> ((push_y == $past(push_y) && push_x == CW'($past(push_x) + 1'b1))
             || push_y == CW'($past(push_y) + 1'b1)))
        else $error("walk skipped or repeated a pixel");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the triangle edge rasterizer
// Drives load and tick beats with random gaps and back-pressure, predicts
// each result beat from a cycle-free model of the box walk and edge tests,
// and compares every output field in order of arrival.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_DIM     = 4096;
    localparam int FRAC_BITS   = 4;
    localparam int PIX_ONE     = 1 << FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [ter_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic          kind;
        ter_pkg::tri_t verts;
        logic [31:0]   colour;   // alpha, red, green, blue from the top
    } raster_req_t;

    typedef struct packed {
        logic        covered;
        logic        done;
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] idx;
        logic [31:0] colour;
    } pixel_result_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [127:0]                    s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [79:0]                     m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ter_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ter_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow state of the rasterizer
    logic [12:0]   frame_w = 13'(ter_pkg::FRAME_W_RESET);
    logic [12:0]   frame_h = 13'(ter_pkg::FRAME_H_RESET);
    ter_pkg::tri_t cur_tri    = '0;
    logic [31:0]   cur_colour = '0;
    int            box_x0, box_y0, box_x1, box_y1;
    int            col, row;
    bit            walking;

    pixel_result_t pending_pixels[$];
    pixel_result_t want;
    int            fault_count = 0;
    int            items_sent  = 0;
    int            hold_left   = 0;
    bit            gaps_on     = 1'b1;

    triangle_edge_rasterizer #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    function automatic int eff_dim(logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int min3(int a, int b, int c);
        int m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic int max3(int a, int b, int c);
        int m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    function automatic longint edge_value(longint ax, longint ay, longint bx, longint by,
                                          longint px, longint py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    // Apply one beat to the shadow state and return the result it must give
    function automatic pixel_result_t predict_pixel(raster_req_t r);
        pixel_result_t res;
        int            lo_x, lo_y, hi_x, hi_y;
        longint        ax, ay, bx, by, cx, cy, px, py, w0, w1, w2;
        res = '0;
        if (r.kind == ter_pkg::REQ_LOAD)
        begin
            cur_tri    = r.verts;
            cur_colour = r.colour;
            lo_x = min3(int'(cur_tri.v0x), int'(cur_tri.v1x), int'(cur_tri.v2x)) >>> FRAC_BITS;
            lo_y = min3(int'(cur_tri.v0y), int'(cur_tri.v1y), int'(cur_tri.v2y)) >>> FRAC_BITS;
            hi_x = max3(int'(cur_tri.v0x), int'(cur_tri.v1x), int'(cur_tri.v2x)) >>> FRAC_BITS;
            hi_y = max3(int'(cur_tri.v0y), int'(cur_tri.v1y), int'(cur_tri.v2y)) >>> FRAC_BITS;
            if (lo_x < 0) lo_x = 0;
            if (lo_y < 0) lo_y = 0;
            if (hi_x > eff_dim(frame_w) - 1) hi_x = eff_dim(frame_w) - 1;
            if (hi_y > eff_dim(frame_h) - 1) hi_y = eff_dim(frame_h) - 1;
            walking = (hi_x >= lo_x) && (hi_y >= lo_y);
            if (walking)
            begin
                box_x0 = lo_x;
                box_y0 = lo_y;
                box_x1 = hi_x;
                box_y1 = hi_y;
            end
            else
            begin
                box_x0 = 0;
                box_y0 = 0;
                box_x1 = 0;
                box_y1 = 0;
            end
            col      = box_x0;
            row      = box_y0;
            res.done = !walking;
        end
        else if (!walking)
        begin
            res.done = 1'b1;
        end
        else
        begin
            // Doubled coordinates put the pixel centre on an integer
            ax = 2 * longint'(cur_tri.v0x);
            ay = 2 * longint'(cur_tri.v0y);
            bx = 2 * longint'(cur_tri.v1x);
            by = 2 * longint'(cur_tri.v1y);
            cx = 2 * longint'(cur_tri.v2x);
            cy = 2 * longint'(cur_tri.v2y);
            px = 2 * PIX_ONE * longint'(col) + PIX_ONE;
            py = 2 * PIX_ONE * longint'(row) + PIX_ONE;
            w0 = edge_value(bx, by, cx, cy, px, py);
            w1 = edge_value(cx, cy, ax, ay, px, py);
            w2 = edge_value(ax, ay, bx, by, px, py);
            res.covered = (w0 >= 0 && w1 >= 0 && w2 >= 0) ||
                          (w0 <= 0 && w1 <= 0 && w2 <= 0);
            res.x   = 12'(col);
            res.y   = 12'(row);
            res.idx = 24'(row * eff_dim(frame_w) + col);
            if (col >= box_x1)
            begin
                col = box_x0;
                if (row >= box_y1)
                begin
                    res.done = 1'b1;
                    walking  = 1'b0;
                end
                else
                    row++;
            end
            else
                col++;
        end
        res.colour = cur_colour;
        return res;
    endfunction

    function automatic int pixels_left();
        if (!walking)
            return 0;
        return (box_y1 - row) * (box_x1 - box_x0 + 1) + (box_x1 - col) + 1;
    endfunction

    function automatic int sat16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic ter_pkg::tri_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy);
        ter_pkg::tri_t t;
        t.v0x = ter_pkg::vert_t'(ax);
        t.v0y = ter_pkg::vert_t'(ay);
        t.v1x = ter_pkg::vert_t'(bx);
        t.v1y = ter_pkg::vert_t'(by);
        t.v2x = ter_pkg::vert_t'(cx);
        t.v2y = ter_pkg::vert_t'(cy);
        return t;
    endfunction

    function automatic raster_req_t load_req(ter_pkg::tri_t t, logic [31:0] colour);
        raster_req_t r;
        r.kind   = ter_pkg::REQ_LOAD;
        r.verts  = t;
        r.colour = colour;
        return r;
    endfunction

    // Tick payload is ignored by the block, so fill it with noise
    function automatic raster_req_t tick_req();
        raster_req_t r;
        r.kind   = ter_pkg::REQ_TICK;
        r.verts  = {$urandom(), $urandom(), $urandom()};
        r.colour = $urandom();
        return r;
    endfunction

    // Small triangle around a random spot of the frame (capped at 2048 pixels), spilling over its edges
    function automatic ter_pkg::tri_t random_small_tri();
        int span, cx, cy, lim_x, lim_y, i;
        int c[6];
        lim_x = (eff_dim(frame_w) > 2048 ? 2048 : eff_dim(frame_w)) * PIX_ONE;
        lim_y = (eff_dim(frame_h) > 2048 ? 2048 : eff_dim(frame_h)) * PIX_ONE;
        span  = int'($urandom_range(128, 8));
        cx    = int'($urandom_range(lim_x + 64)) - 32;
        cy    = int'($urandom_range(lim_y + 64)) - 32;
        for (i = 0; i < 3; i++)
        begin
            c[2*i]   = sat16(cx + int'($urandom_range(2 * span)) - span);
            c[2*i+1] = sat16(cy + int'($urandom_range(2 * span)) - span);
        end
        // Put vertices on pixel centres so that edges pass through test points
        if ($urandom_range(99) < 30)
            for (i = 0; i < 6; i++)
                c[i] = (c[i] >>> FRAC_BITS) * PIX_ONE + PIX_ONE / 2;
        if ($urandom_range(99) < 10)
        begin
            c[4] = (c[0] + c[2]) >>> 1;
            c[5] = (c[1] + c[3]) >>> 1;
        end
        return mk_tri(c[0], c[1], c[2], c[3], c[4], c[5]);
    endfunction

    task automatic offer_beat(raster_req_t r);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {r.colour, r.verts.v2y, r.verts.v2x, r.verts.v1y, r.verts.v1x,
                     r.verts.v0y, r.verts.v0x};
        do
            @(posedge clk);
        while (!s_tready);
        pending_pixels.push_back(predict_pixel(r));
        items_sent++;
    endtask

    task automatic tick_n(int n);
        repeat (n) offer_beat(tick_req());
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_reg(logic [ter_pkg::CFG_INDEX_W-1:0] index,
                                   logic [12:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == ter_pkg::REG_FRAME_WIDTH)
            frame_w = value;
        else if (index == ter_pkg::REG_FRAME_HEIGHT)
            frame_h = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h);
        wait_results_drained();
        write_frame_reg(ter_pkg::REG_FRAME_WIDTH, w);
        write_frame_reg(ter_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // Receiver: long hold-offs first, then random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (gaps_on && $urandom_range(99) < 14)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string field, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            if (fault_count < 10)
                $display("mismatch on %s: expected %0d, got %0d", field, exp_v, got_v);
            fault_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                if (fault_count < 10)
                    $display("result beat with nothing pending: %h", m_tdata);
                fault_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("covered",     longint'(want.covered), longint'(m_tuser));
                check_field("walk_done",   longint'(want.done),    longint'(m_tlast));
                check_field("pixel_x",     longint'(want.x),       longint'(m_tdata[11:0]));
                check_field("pixel_y",     longint'(want.y),       longint'(m_tdata[23:12]));
                check_field("pixel_index", longint'(want.idx),     longint'(m_tdata[47:24]));
                check_field("out_blue",    longint'(want.colour[7:0]),
                            longint'(m_tdata[55:48]));
                check_field("out_green",   longint'(want.colour[15:8]),
                            longint'(m_tdata[63:56]));
                check_field("out_red",     longint'(want.colour[23:16]),
                            longint'(m_tdata[71:64]));
                check_field("out_alpha",   longint'(want.colour[31:24]),
                            longint'(m_tdata[79:72]));
            end
        end
    end

    task automatic test_directed_cases();
        tick_n(1);
        // Wholly above-left, then wholly below-right: no walk starts
        offer_beat(load_req(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768), '0));
        tick_n(1);
        offer_beat(load_req(mk_tri(32767, 32767, 32767, 32767, 32767, 32767), '1));
        offer_beat(load_req(mk_tri(8, 8, 24, 8, 8, 24), 32'h11223344));
        tick_n(5);
        // Opposite winding
        offer_beat(load_req(mk_tri(8, 8, 8, 24, 24, 8), 32'hA5C3F00F));
        tick_n(4);
        // All three vertices on one point
        offer_beat(load_req(mk_tri(40, 40, 40, 40, 40, 40), 32'h5A3C0FF0));
        tick_n(1);
        // Negative minima clamp to the frame corner
        offer_beat(load_req(mk_tri(-16, -16, 24, -8, 0, 24), $urandom()));
        tick_n(4);
    endtask

    task automatic test_frame_extremes();
        set_frame(13'd1, 13'd1);
        offer_beat(load_req(mk_tri(0, 0, 32, 0, 0, 32), $urandom()));
        tick_n(2);
        set_frame(13'd4096, 13'd4096);
        offer_beat(load_req(mk_tri(32720, 32720, 32767, 32720, 32720, 32767), $urandom()));
        tick_n(pixels_left() + 1);
        offer_beat(load_req(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767), $urandom()));
        tick_n(5);
        // Out-of-range register values clamp to the legal span
        set_frame(13'd0, 13'd0);
        offer_beat(load_req(mk_tri(0, 0, 40, 8, 8, 40), $urandom()));
        tick_n(2);
        set_frame(13'd8191, 13'd8191);
        offer_beat(load_req(mk_tri(32700, 32750, 32767, 32767, 32740, 32710), $urandom()));
        tick_n(pixels_left() + 1);
        wait_results_drained();
        write_frame_reg(REG_UNUSED, 13'($urandom()));
        offer_beat(load_req(mk_tri(100, 100, 150, 110, 120, 160), $urandom()));
        tick_n(pixels_left());
        // Change the frame halfway through a walk: box holds, index follows width
        set_frame(13'd640, 13'd480);
        offer_beat(load_req(mk_tri(8, 8, 56, 16, 24, 60), $urandom()));
        tick_n(6);
        set_frame(13'd100, 13'd2);
        tick_n(pixels_left() + 1);
    endtask

    task automatic test_backpressure();
        set_frame(13'd640, 13'd480);
        offer_beat(load_req(mk_tri(160, 160, 320, 170, 200, 330), $urandom()));
        hold_left = 120;
        tick_n(40);
        wait_results_drained();
        tick_n(pixels_left() + 1);
        wait_results_drained();
    endtask

    task automatic random_walks(int count);
        int stop_at, pick, n;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = int'($urandom_range(99));
            if (pick < 70)
            begin
                offer_beat(load_req(random_small_tri(), $urandom()));
                n = pixels_left();
                if (n > 300)
                    n = int'($urandom_range(20, 1));
                tick_n(n + int'($urandom_range(2)));
            end
            else if (pick < 85)
            begin
                offer_beat(load_req(ter_pkg::tri_t'({$urandom(), $urandom(), $urandom()}),
                                    $urandom()));
                tick_n(int'($urandom_range(5)));
            end
            else
                tick_n(int'($urandom_range(6, 1)));
        end
    endtask

    task automatic test_random_frames();
        logic [12:0] widths[9]  = '{640, 1, 4096, 33, 1, 4096, 0, 8191, 200};
        logic [12:0] heights[9] = '{480, 1, 4096, 17, 4096, 1, 8191, 0, 150};
        int i;
        for (i = 0; i < 9; i++)
        begin
            set_frame(widths[i], heights[i]);
            // One whole phase runs without any gaps on either side
            gaps_on = (i != 3);
            random_walks(180);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_frame_extremes();
        test_backpressure();
        test_random_frames();
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fault_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
